>>> rtl/core/lpmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed message deframer package
// Shared constants and the result record passed from the front end, through
// the queue, to the output stage.
// ----------------------------------------------------------------------------
package lpmd_pkg;

  localparam logic [1:0] FuncData   = 2'd0;
  localparam logic [1:0] FuncCancel = 2'd1;
  localparam logic [1:0] FuncNew    = 2'd2;

  // Header is one flag byte and a 32-bit big-endian length.
  localparam int unsigned HdrBytes = 5;
  localparam logic [2:0]  HdrLast  = 3'(HdrBytes - 1);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       msg_last;
    logic       empty_msg;
    logic [7:0] msg_flag;
    logic       finished;
    logic       truncated;
  } lpmd_result_t;

endpackage

>>> rtl/core/lpmd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer front end
// Tracks header, payload, cancel and end-of-stream phases for each accepted
// transfer and builds the result record, if the transfer produces one.
// ----------------------------------------------------------------------------
module lpmd_front
  import lpmd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         acc,
  input  logic [1:0]   func,
  input  logic [7:0]   data_byte,
  input  logic         stream_end,
  output logic         push,
  output lpmd_result_t res
);

  localparam logic [1:0] PhHeader    = 2'd0;
  localparam logic [1:0] PhPayload   = 2'd1;
  localparam logic [1:0] PhCancelled = 2'd2;
  localparam logic [1:0] PhEnded     = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] left_r, left_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [31:0] len_val;
  logic [7:0]  flag_val;
  logic        trunc;

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    flag_nxt  = flag_r;
    res       = '0;
    push      = 1'b0;
    trunc     = 1'b0;
    len_val   = (hcnt_r == 3'd0) ? 32'd0 : {len_r[23:0], data_byte};
    flag_val  = (hcnt_r == 3'd0) ? data_byte : flag_r;
    if (acc) begin
      case (func)
        FuncCancel: begin
          phase_nxt = PhCancelled;
        end
        FuncNew: begin
          phase_nxt = PhHeader;
          hcnt_nxt  = 3'd0;
          len_nxt   = 32'd0;
          left_nxt  = 32'd0;
          flag_nxt  = 8'd0;
        end
        FuncData: begin
          if (phase_r == PhHeader) begin
            res.msg_flag = flag_val;
            flag_nxt     = flag_val;
            if (hcnt_r == HdrLast) begin
              hcnt_nxt = 3'd0;
              len_nxt  = 32'd0;
              if (len_val == 32'd0) begin
                res.empty_msg = 1'b1;
                flag_nxt      = 8'd0;
              end else begin
                left_nxt  = len_val;
                phase_nxt = PhPayload;
                trunc     = 1'b1;
              end
            end else begin
              hcnt_nxt = hcnt_r + 3'd1;
              len_nxt  = len_val;
              trunc    = 1'b1;
            end
          end else if (phase_r == PhPayload) begin
            res.payload_byte  = data_byte;
            res.payload_valid = 1'b1;
            res.msg_flag      = flag_r;
            left_nxt          = left_r - 32'd1;
            if (left_r == 32'd1) begin
              res.msg_last = 1'b1;
              phase_nxt    = PhHeader;
              hcnt_nxt     = 3'd0;
              flag_nxt     = 8'd0;
            end else begin
              trunc = 1'b1;
            end
          end
          if (phase_r == PhHeader || phase_r == PhPayload) begin
            if (stream_end) begin
              phase_nxt    = PhEnded;
              res.finished = 1'b1;
            end
            res.truncated = trunc & stream_end;
            push = res.payload_valid | res.empty_msg | stream_end;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PhHeader;
      hcnt_r  <= 3'd0;
      len_r   <= 32'd0;
      left_r  <= 32'd0;
      flag_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      flag_r  <= flag_nxt;
    end
  end

endmodule

>>> rtl/core/lpmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer result queue
// Short shifting queue between the front end and the output stage; the head
// always sits in the first slot.
// ----------------------------------------------------------------------------
module lpmd_queue
  import lpmd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  lpmd_result_t push_data,
  input  logic         pop,
  output logic         not_full,
  output logic         head_valid,
  output lpmd_result_t head_data
);

  lpmd_result_t         q_r   [QDepth];
  lpmd_result_t         q_nxt [QDepth];
  logic [QCntW-1:0]     cnt_r, cnt_nxt;
  logic [QCntW-1:0]     wr_pos;

  assign not_full   = (cnt_r != QCntW'(QDepth));
  assign head_valid = (cnt_r != '0);
  assign head_data  = q_r[0];

  always_comb begin
    wr_pos  = cnt_r - QCntW'(pop);
    cnt_nxt = cnt_r + QCntW'(push) - QCntW'(pop);
    for (int i = 0; i < QDepth; i++) begin
      if (pop && (i + 1 < QDepth)) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push && (wr_pos == QCntW'(i))) begin
        q_nxt[i] = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDepth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

>>> rtl/core/lpmd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer output stage
// Registered result holder that takes the queue head whenever it is empty or
// its current transfer completes.
// ----------------------------------------------------------------------------
module lpmd_back
  import lpmd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         head_valid,
  input  lpmd_result_t head_data,
  output logic         pop,
  input  logic         out_ready,
  output logic         out_valid,
  output lpmd_result_t out_data
);

  logic         valid_r, valid_nxt;
  lpmd_result_t data_r;
  logic         take;

  assign take      = !valid_r || out_ready;
  assign pop       = take && head_valid;
  assign valid_nxt = take ? head_valid : valid_r;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= head_data;
    end
  end

endmodule

>>> rtl/core/length_prefixed_message_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed message deframer
// Splits a byte stream of flag/length-prefixed messages into payload bytes,
// marks message ends and empty messages, and reports the end of the stream.
//
//   Group  Direction  tdata                         tuser / tlast
//   in_    slave      [7:0] data_byte               tuser func, tlast stream_end
//   out_   master     [7:0] payload_byte,           tuser {truncated, finished,
//                     [15:8] msg_flag                 empty_msg, payload_valid}
//                                                   tlast msg_last
//
// One input transfer is accepted per cycle while in_tready is high; the front
// end updates its phase and counters in the cycle of acceptance.
// A result is registered in the queue, then in the output register, before it
// shows on out_tvalid; while out_tready is low it waits in the queue.
// in_tready falls only when the two-entry queue is full.
// rst_n is synchronous and returns the block to the header phase.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer_top
  import lpmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] func
  input  logic        in_tlast,   // stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] payload_byte, [15:8] msg_flag
  output logic [3:0]  out_tuser,  // [0] payload_valid, [1] empty_msg,
                                  // [2] finished, [3] truncated
  output logic        out_tlast   // msg_last
);

  logic         acc;
  logic         push;
  lpmd_result_t push_data;
  logic         pop;
  logic         head_valid;
  lpmd_result_t head_data;
  lpmd_result_t out_data;

  assign acc = in_tvalid && in_tready;

  lpmd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .func       (in_tuser),
    .data_byte  (in_tdata),
    .stream_end (in_tlast),
    .push       (push),
    .res        (push_data)
  );

  lpmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .not_full   (in_tready),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  lpmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_data)
  );

  assign out_tdata = {out_data.msg_flag, out_data.payload_byte};
  assign out_tuser = {out_data.truncated, out_data.finished,
                      out_data.empty_msg, out_data.payload_valid};
  assign out_tlast = out_data.msg_last;

endmodule

>>> rtl/core/lpmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer port checker
// Concurrent checks on the ports of the deframer, attached by a bind.
// ----------------------------------------------------------------------------
module lpmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Output transfer withdrawn before completion.");

  a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0] && !out_tuser[1])
    else $error("Message end marked on a transfer without a payload byte.");

  a_trunc_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tuser[2] && !out_tlast)
    else $error("Truncation reported away from the end of the stream.");

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[7:0] == 8'd0)
    else $error("Payload byte set on a transfer without payload.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("Block not idle after reset.");

endmodule

bind length_prefixed_message_deframer_top lpmd_checker u_lpmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> verif/length_prefixed_message_deframer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed message deframer testbench
// Drives directed and random byte streams of flag/length-prefixed messages,
// with cancels, new streams, truncated ends and ignored bytes, into the input
// channel. A scoreboard predicts every output transfer from the accepted
// input transfers and checks the results in order. Both sides idle at random,
// and the receiver holds off once for long enough to fill the block.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer_top_test;
  import lpmd_pkg::*;

  localparam logic [1:0] FuncUnknown = 2'd3;

  typedef enum logic [1:0] {
    PhHeader,
    PhPayload,
    PhCancelled,
    PhEnded
  } deframe_phase_t;

  class deframe_scoreboard;
    deframe_phase_t phase;
    logic [2:0]     hdr_seen;
    logic [31:0]    len_acc;
    logic [31:0]    remaining;
    logic [7:0]     flag;
    lpmd_result_t   expected_results[$];
    int             mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      phase     = PhHeader;
      hdr_seen  = '0;
      len_acc   = '0;
      remaining = '0;
      flag      = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Returns 1 when the transfer was a data byte that the block processed.
    function bit note_transfer(logic [1:0] func, logic [7:0] rx_byte, logic stream_end);
      lpmd_result_t r;
      r = '0;
      case (func)
        FuncCancel: begin
          phase = PhCancelled;
          return 0;
        end
        FuncNew: begin
          clear();
          return 0;
        end
        FuncData: ;
        default: return 0;
      endcase
      if (phase == PhCancelled || phase == PhEnded) return 0;
      if (phase == PhHeader) begin
        if (hdr_seen == 3'd0) begin
          flag    = rx_byte;
          len_acc = '0;
        end else begin
          len_acc = {len_acc[23:0], rx_byte};
        end
        hdr_seen   = hdr_seen + 3'd1;
        r.msg_flag = flag;
        if (hdr_seen >= HdrBytes) begin
          hdr_seen = '0;
          if (len_acc == 32'd0) begin
            r.empty_msg = 1'b1;
            flag        = '0;
          end else begin
            remaining   = len_acc;
            phase       = PhPayload;
            r.truncated = 1'b1;
          end
          len_acc = '0;
        end else begin
          r.truncated = 1'b1;
        end
      end else begin
        r.payload_byte  = rx_byte;
        r.payload_valid = 1'b1;
        r.msg_flag      = flag;
        remaining       = remaining - 32'd1;
        if (remaining == 32'd0) begin
          r.msg_last = 1'b1;
          phase      = PhHeader;
          hdr_seen   = '0;
          flag       = '0;
        end else begin
          r.truncated = 1'b1;
        end
      end
      if (stream_end) begin
        phase      = PhEnded;
        r.finished = 1'b1;
      end else begin
        r.truncated = 1'b0;
      end
      if (r.payload_valid || r.empty_msg || stream_end)
        expected_results.insert(expected_results.size(), r);
      return 1;
    endfunction

    function void check_result(lpmd_result_t got);
      lpmd_result_t want;
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result byte=%h valid=%b last=%b empty=%b flag=%h fin=%b trunc=%b",
                   $realtime, got.payload_byte, got.payload_valid, got.msg_last,
                   got.empty_msg, got.msg_flag, got.finished, got.truncated);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.payload_byte !== want.payload_byte || got.payload_valid !== want.payload_valid ||
          got.msg_last !== want.msg_last || got.empty_msg !== want.empty_msg ||
          got.msg_flag !== want.msg_flag || got.finished !== want.finished ||
          got.truncated !== want.truncated) begin
        if (mismatches < 10) begin
          $display("%0t: mismatch expected byte=%h valid=%b last=%b empty=%b flag=%h fin=%b trunc=%b",
                   $realtime, want.payload_byte, want.payload_valid, want.msg_last,
                   want.empty_msg, want.msg_flag, want.finished, want.truncated);
          $display("%0t:          actual   byte=%h valid=%b last=%b empty=%b flag=%h fin=%b trunc=%b",
                   $realtime, got.payload_byte, got.payload_valid, got.msg_last,
                   got.empty_msg, got.msg_flag, got.finished, got.truncated);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic [1:0]  in_tuser = '0;   // [1:0] func
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [7:0] payload_byte, [15:8] msg_flag
  logic [3:0]  out_tuser;       // [0] payload_valid, [1] empty_msg, [2] finished, [3] truncated
  logic        out_tlast;

  deframe_scoreboard sb;
  int items_used = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  length_prefixed_message_deframer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_item(logic [1:0] func, logic [7:0] rx_byte, logic stream_end);
    while (!calm && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= rx_byte;
    in_tlast  <= stream_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (sb.note_transfer(func, rx_byte, stream_end)) items_used++;
  endtask

  // One stream: a new-stream transfer, a few messages, then a clean end, a
  // truncated end, a cancel or no end at all.
  task automatic play_stream();
    logic [7:0]  stream_bytes[$];
    logic [31:0] len_word;
    int          n_msgs;
    int          pick;
    int          n_payload;
    int          mode;
    int          cut;
    send_item(FuncNew, 8'($urandom), 1'($urandom));
    n_msgs = $urandom_range(1, 5);
    for (int m = 0; m < n_msgs; m++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        len_word = '0;
      end else if (pick < 85) begin
        len_word = $urandom_range(1, 8);
      end else if (pick < 97) begin
        len_word = $urandom_range(9, 40);
      end else begin
        len_word = $urandom | 32'h0100_0000;
      end
      n_payload = (pick < 97) ? int'(len_word) : $urandom_range(0, 4);
      stream_bytes.insert(stream_bytes.size(), 8'($urandom));
      stream_bytes.insert(stream_bytes.size(), len_word[31:24]);
      stream_bytes.insert(stream_bytes.size(), len_word[23:16]);
      stream_bytes.insert(stream_bytes.size(), len_word[15:8]);
      stream_bytes.insert(stream_bytes.size(), len_word[7:0]);
      for (int i = 0; i < n_payload; i++)
        stream_bytes.insert(stream_bytes.size(), 8'($urandom));
      if (pick >= 97) break;
    end
    mode = $urandom_range(99);
    cut = (mode < 50 || mode >= 85) ? stream_bytes.size() - 1
                                    : $urandom_range(0, stream_bytes.size() - 1);
    for (int i = 0; i <= cut; i++) begin
      if ($urandom_range(99) < 3) send_item(FuncUnknown, 8'($urandom), 1'($urandom));
      send_item(FuncData, stream_bytes[i], (mode < 70) && (i == cut));
    end
    if (mode >= 70 && mode < 85) send_item(FuncCancel, 8'($urandom), 1'($urandom));
    if (mode < 85) begin
      repeat ($urandom_range(0, 3)) send_item(FuncData, 8'($urandom), 1'($urandom));
    end
  endtask

  // Receiver; a hold-off request stalls it for a long run of cycles.
  initial begin
    int hold_cnt;
    lpmd_result_t got;
    hold_cnt = 0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 36);
      end
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.payload_byte  = out_tdata[7:0];
        got.msg_flag      = out_tdata[15:8];
        got.payload_valid = out_tuser[0];
        got.empty_msg     = out_tuser[1];
        got.finished      = out_tuser[2];
        got.truncated     = out_tuser[3];
        got.msg_last      = out_tlast;
        sb.check_result(got);
      end
    end
  end

  initial begin
    bit held;
    held = 1'b0;
    sb = new();
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message with an all-ones flag.
    send_item(FuncData, 8'hFF, 1'b0);
    repeat (4) send_item(FuncData, 8'h00, 1'b0);
    // One-byte message whose only byte also ends the stream.
    send_item(FuncData, 8'h00, 1'b0);
    send_item(FuncData, 8'h00, 1'b0);
    send_item(FuncData, 8'h00, 1'b0);
    send_item(FuncData, 8'h00, 1'b0);
    send_item(FuncData, 8'h01, 1'b0);
    send_item(FuncData, 8'hFF, 1'b1);
    // Data after the end, and an unknown function, are both ignored.
    send_item(FuncData, 8'h12, 1'b1);
    send_item(FuncUnknown, 8'hFF, 1'b1);
    // Largest length, one payload byte, then a cancel.
    send_item(FuncNew, 8'h00, 1'b0);
    send_item(FuncData, 8'h80, 1'b0);
    repeat (4) send_item(FuncData, 8'hFF, 1'b0);
    send_item(FuncData, 8'h3C, 1'b0);
    send_item(FuncCancel, 8'h00, 1'b0);
    send_item(FuncData, 8'h55, 1'b1);
    // Stream that ends on its first header byte.
    send_item(FuncNew, 8'hAA, 1'b1);
    send_item(FuncData, 8'h7E, 1'b1);

    while (items_used < 1600) begin
      calm = (items_used >= 1100 && items_used < 1400);
      if (!held && items_used >= 700) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      play_stream();
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lpmd_pkg.sv
rtl/core/lpmd_front.sv
rtl/core/lpmd_queue.sv
rtl/core/lpmd_back.sv
rtl/core/length_prefixed_message_deframer_top.sv
rtl/core/lpmd_checker.sv
verif/length_prefixed_message_deframer_top_test.sv
